### hdl/fpgt_pkg.sv
// ----------------------------------------------------------------------------
// fpgt_pkg
// Types and field widths shared by the frame and packet gap tracker.
// ----------------------------------------------------------------------------
package fpgt_pkg;

   localparam int STREAM_W = 32;
   localparam int FRAME_W  = 48;
   localparam int PACKET_W = 32;
   localparam int OFFSET_W = 32;
   localparam int LENGTH_W = 16;
   localparam int COUNT_W  = 48;

   typedef struct packed {
      logic [STREAM_W-1:0] stream_ident;
      logic [FRAME_W-1:0]  frame_number;
      logic [PACKET_W-1:0] packet_number;
      logic [OFFSET_W-1:0] byte_offset;
      logic [LENGTH_W-1:0] payload_bytes;
      logic                frame_start;
      logic                frame_end;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] packet_gap_count;
      logic [COUNT_W-1:0] frame_gap_count;
      logic [COUNT_W-1:0] frames_begun;
      logic [COUNT_W-1:0] frames_finished;
   } rsp_type;

endpackage

### hdl/frame_packet_gap_tracker_core.sv
// ----------------------------------------------------------------------------
// frame_packet_gap_tracker_core
// Follows one stream of packet headers and counts missing frames, missing
// packets, frames begun and frames finished; returns all four per packet.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   req     | in        | req_valid, req_stall | fpgt_pkg::req_type (header)
//   rsp     | out       | rsp_valid, rsp_stall | fpgt_pkg::rsp_type (counters)
//
// One item per cycle sustained while the result is not stalled.
// The header lands in an input register, the tracking update runs between it
// and the result register, and the tracking state updates in the same cycle.
// Reset (synchronous) empties both registers and clears all tracking state.
// A stalled result holds the input register; an empty input register still
// takes one more item before req_stall rises.
// ----------------------------------------------------------------------------
module frame_packet_gap_tracker_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fpgt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fpgt_pkg::rsp_type rsp_data
);

   import fpgt_pkg::*;

   localparam logic [COUNT_W-1:0] CNT_MAX = {COUNT_W{1'b1}};

   function automatic logic [COUNT_W-1:0] sat_add(
      input logic [COUNT_W-1:0] c,
      input logic [FRAME_W-1:0] d
   );
      logic [64:0] sum;
      sum = 65'(c) + 65'(d);
      if (sum > 65'(CNT_MAX)) begin
         return CNT_MAX;
      end
      return sum[COUNT_W-1:0];
   endfunction

   // pipeline control
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    req_take;
   logic    advance;

   // tracking state
   logic                seen_packet_ff, seen_packet_in;
   logic                seen_frame_ff, seen_frame_in;
   logic [STREAM_W-1:0] stream_ff, stream_in;
   logic [FRAME_W-1:0]  frame_ff, frame_in;
   logic [PACKET_W-1:0] exp_packet_ff, exp_packet_in;
   logic [OFFSET_W-1:0] exp_byte_ff, exp_byte_in;
   logic [COUNT_W-1:0]  packet_gaps_ff, packet_gaps_in;
   logic [COUNT_W-1:0]  frame_gaps_ff, frame_gaps_in;
   logic [COUNT_W-1:0]  started_ff, started_in;
   logic [COUNT_W-1:0]  complete_ff, complete_in;

   // working values
   logic                clear_all;
   logic                base_seen_frame;
   logic [FRAME_W-1:0]  base_frame;
   logic [PACKET_W-1:0] base_exp_packet;
   logic [OFFSET_W-1:0] base_exp_byte;
   logic [COUNT_W-1:0]  base_packet_gaps;
   logic [COUNT_W-1:0]  base_frame_gaps;
   logic [COUNT_W-1:0]  base_started;
   logic [COUNT_W-1:0]  base_complete;
   logic                frame_switch;
   logic                frame_skip;
   logic [FRAME_W-1:0]  frame_gap;
   logic [PACKET_W-1:0] chk_packet;
   logic [OFFSET_W-1:0] chk_byte;
   logic [PACKET_W:0]   packet_add;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   end

   always_comb begin
      // a new stream or the very first packet starts from a clean slate
      clear_all        = !seen_packet_ff || (stream_ff != in_data_ff.stream_ident);
      base_seen_frame  = clear_all ? 1'b0 : seen_frame_ff;
      base_frame       = clear_all ? '0 : frame_ff;
      base_exp_packet  = clear_all ? '0 : exp_packet_ff;
      base_exp_byte    = clear_all ? '0 : exp_byte_ff;
      base_packet_gaps = clear_all ? '0 : packet_gaps_ff;
      base_frame_gaps  = clear_all ? '0 : frame_gaps_ff;
      base_started     = clear_all ? '0 : started_ff;
      base_complete    = clear_all ? '0 : complete_ff;

      frame_switch = in_data_ff.frame_start || !base_seen_frame ||
                     (in_data_ff.frame_number != base_frame);
      frame_skip   = frame_switch && base_seen_frame &&
                     ({1'b0, in_data_ff.frame_number} > ({1'b0, base_frame} + 49'd1));
      frame_gap    = in_data_ff.frame_number - base_frame - 48'd1;

      chk_packet = base_exp_packet;
      chk_byte   = base_exp_byte;
      if (in_data_ff.frame_start) begin
         chk_packet = '0;
         chk_byte   = '0;
      end else if (frame_switch) begin
         chk_packet = in_data_ff.packet_number;
         chk_byte   = in_data_ff.byte_offset;
      end

      // missing packets plus one for an offset mismatch, folded into one add
      packet_add = (in_data_ff.packet_number > chk_packet) ?
                   {1'b0, in_data_ff.packet_number - chk_packet} : '0;
      if (in_data_ff.byte_offset != chk_byte) begin
         packet_add = packet_add + 33'd1;
      end

      seen_packet_in = 1'b1;
      seen_frame_in  = 1'b1;
      stream_in      = in_data_ff.stream_ident;
      frame_in       = in_data_ff.frame_number;
      exp_packet_in  = in_data_ff.packet_number + 32'd1;
      exp_byte_in    = in_data_ff.byte_offset + 32'(in_data_ff.payload_bytes);
      packet_gaps_in = sat_add(base_packet_gaps, 48'(packet_add));
      frame_gaps_in  = frame_skip ? sat_add(base_frame_gaps, frame_gap) : base_frame_gaps;
      started_in     = in_data_ff.frame_start ? sat_add(base_started, 48'd1) : base_started;
      complete_in    = in_data_ff.frame_end ? sat_add(base_complete, 48'd1) : base_complete;

      rsp_data_in.packet_gap_count = 48'(64'(packet_gaps_in));
      rsp_data_in.frame_gap_count  = 48'(64'(frame_gaps_in));
      rsp_data_in.frames_begun     = 48'(64'(started_in));
      rsp_data_in.frames_finished  = 48'(64'(complete_in));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         seen_packet_ff <= 1'b0;
         seen_frame_ff  <= 1'b0;
         stream_ff      <= '0;
         frame_ff       <= '0;
         exp_packet_ff  <= '0;
         exp_byte_ff    <= '0;
         packet_gaps_ff <= '0;
         frame_gaps_ff  <= '0;
         started_ff     <= '0;
         complete_ff    <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            seen_packet_ff <= seen_packet_in;
            seen_frame_ff  <= seen_frame_in;
            stream_ff      <= stream_in;
            frame_ff       <= frame_in;
            exp_packet_ff  <= exp_packet_in;
            exp_byte_ff    <= exp_byte_in;
            packet_gaps_ff <= packet_gaps_in;
            frame_gaps_ff  <= frame_gaps_in;
            started_ff     <= started_in;
            complete_ff    <= complete_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // an empty input register never pushes back
   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> !req_stall)
      else $error("req_stall raised with empty input register");

   // every processed item shows up as a result
   a_advance_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed item did not reach the result register");

   // a held item is not lost
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("held item dropped from input register");

   // the frames begun counter only grows within one stream
   a_started_monotonic: assert property (@(posedge clock) disable iff (reset)
      (advance && !clear_all) |=> (started_ff >= $past(started_ff)))
      else $error("frames begun counter decreased within a stream");

endmodule
